/* sv/lspc_pkg.sv */
// Package for the latency slice pass checker: payload structs, register codes,
// configuration bundle and helper functions. No dependencies.
package lspc_pkg;

    localparam int COUNT_BITS  = 48;
    localparam int NUM_CRIT    = 3;
    localparam int NS_W        = 48;
    localparam int USEC_W      = 24;
    localparam int LIMIT_W     = 10;
    localparam int SLICE_W     = 16;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int BUCKET_W    = 2;
    localparam int NS_PER_US   = 1000;
    // 1000 * (2^24) stays below 2^34, plus margin for the +1
    localparam int THR_NS_W    = 35;
    localparam int PROD_W      = COUNT_BITS + LIMIT_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THR_LOW     = 3'd0,
        REG_THR_MID     = 3'd1,
        REG_THR_HIGH    = 3'd2,
        REG_LIM_LOW     = 3'd3,
        REG_LIM_MID     = 3'd4,
        REG_LIM_HIGH    = 3'd5,
        REG_SLICE_COUNT = 3'd6,
        REG_DISABLE     = 3'd7
    } lspc_reg_t;

    typedef struct packed {
        logic [NS_W-1:0] latency_ns;
        logic            period_elapsed;
    } lspc_in_t;

    typedef struct packed {
        logic                counted;
        logic                slice_closed;
        logic                criterion_failed;
        logic [BUCKET_W-1:0] failed_bucket;
        logic [SLICE_W-1:0]  slice_number;
    } lspc_out_t;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic                hit;
        logic [BUCKET_W-1:0] bucket;
        logic                elapsed;
    } lspc_cls_t;

    typedef struct packed {
        logic [NUM_CRIT-1:0][THR_NS_W-1:0] thr_ns;
        logic [NUM_CRIT-1:0][LIMIT_W-1:0]  limit;
        logic [SLICE_W-1:0]                slice_count;
        logic                              disabled;
    } lspc_cfg_t;

    typedef struct packed {
        logic               counted;
        logic               closed;
        logic [SLICE_W-1:0] slice_number;
    } lspc_meta_t;

    // usec > T  <=>  floor(ns/1000) >= T+1  <=>  ns >= 1000*(T+1)
    function automatic logic [THR_NS_W-1:0] thr_to_ns(input logic [USEC_W-1:0] t_us);
        logic [THR_NS_W-1:0] t_ext;
        t_ext = THR_NS_W'(t_us) + THR_NS_W'(1);
        return THR_NS_W'(t_ext * THR_NS_W'(NS_PER_US));
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

endpackage

/* sv/lspc_front.sv */
// Front end of the latency slice pass checker: classifies each beat into a
// latency bucket and pushes it into the queue. Depends on lspc_pkg.
module lspc_front
    import lspc_pkg::*;
(
    input  logic      in_valid,
    output logic      in_stall,
    input  lspc_in_t  in_data,
    input  lspc_cfg_t cfg,
    input  logic      q_full,
    output logic      q_push,
    output lspc_cls_t q_data
);

    always_comb
    begin
        q_data.hit     = 1'b0;
        q_data.bucket  = '0;
        q_data.elapsed = in_data.period_elapsed;
        // ascending scan: the highest-index bucket whose threshold is met wins
        for (int i = 0; i < NUM_CRIT; i++)
        begin
            if (in_data.latency_ns >= NS_W'(cfg.thr_ns[i]))
            begin
                q_data.hit    = 1'b1;
                q_data.bucket = BUCKET_W'(i);
            end
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

/* sv/lspc_queue.sv */
// Short FIFO between front and back of the latency slice pass checker.
// Depends on lspc_pkg for the entry type and depth.
module lspc_queue
    import lspc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lspc_cls_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output lspc_cls_t pop_data
);

    lspc_cls_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
`endif

endmodule

/* sv/lspc_back.sv */
// Back end of the latency slice pass checker: slice counters, product stage
// and criterion compare feeding the output register. Depends on lspc_pkg.
module lspc_back
    import lspc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lspc_cfg_t cfg,
    input  logic      q_valid,
    output logic      q_pop,
    input  lspc_cls_t q_data,
    output logic      out_valid,
    input  logic      out_stall,
    output lspc_out_t out_data
);

    // slice state
    logic [COUNT_BITS-1:0] bucket_reg [NUM_CRIT];
    logic [COUNT_BITS-1:0] bucket_next [NUM_CRIT];
    logic [COUNT_BITS-1:0] bucket_inc [NUM_CRIT];
    logic [COUNT_BITS-1:0] total_reg, total_next, total_inc;
    logic [SLICE_W-1:0]    slice_reg, slice_next;

    // stage 1: snapshot of a closed slice
    logic                  s1_valid_reg;
    lspc_meta_t            s1_meta_reg, s1_meta_next;
    logic [COUNT_BITS-1:0] snap_bucket_reg [NUM_CRIT];
    logic [COUNT_BITS-1:0] snap_total_reg;

    // stage 2: products
    logic                  s2_valid_reg;
    lspc_meta_t            s2_meta_reg;
    logic [PROD_W-1:0]     lhs_reg [NUM_CRIT];
    logic [PROD_W-1:0]     rhs_reg [NUM_CRIT];

    // stage 3: result
    logic                  out_valid_reg;
    lspc_out_t             out_reg, out_next;

    logic advance;
    logic enabled;
    logic take;
    logic closing;

    always_comb
    begin
        advance  = !(out_valid_reg && out_stall);
        q_pop    = advance && q_valid;
        enabled  = !cfg.disabled && (slice_reg < cfg.slice_count);
        take     = q_pop && enabled;
        closing  = take && q_data.elapsed;

        total_inc  = sat_inc(total_reg);
        total_next = total_reg;
        slice_next = slice_reg;
        for (int i = 0; i < NUM_CRIT; i++)
        begin
            bucket_inc[i]  = (q_data.hit && q_data.bucket == BUCKET_W'(i))
                             ? sat_inc(bucket_reg[i]) : bucket_reg[i];
            bucket_next[i] = bucket_reg[i];
        end

        if (take)
        begin
            total_next = total_inc;
            for (int i = 0; i < NUM_CRIT; i++)
            begin
                bucket_next[i] = bucket_inc[i];
            end
        end
        // drop the slice once its snapshot is taken
        if (closing)
        begin
            total_next = '0;
            slice_next = slice_reg + SLICE_W'(1);
            for (int i = 0; i < NUM_CRIT; i++)
            begin
                bucket_next[i] = '0;
            end
        end

        s1_meta_next.counted      = enabled;
        s1_meta_next.closed       = enabled && q_data.elapsed;
        s1_meta_next.slice_number = slice_reg;
    end

    // first failing criterion, low bucket first
    always_comb
    begin
        out_next.counted          = s2_meta_reg.counted;
        out_next.slice_closed     = s2_meta_reg.closed;
        out_next.slice_number     = s2_meta_reg.slice_number;
        out_next.criterion_failed = 1'b0;
        out_next.failed_bucket    = '0;
        if (s2_meta_reg.closed)
        begin
            for (int i = NUM_CRIT - 1; i >= 0; i--)
            begin
                if (lhs_reg[i] >= rhs_reg[i])
                begin
                    out_next.criterion_failed = 1'b1;
                    out_next.failed_bucket    = BUCKET_W'(i);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            slice_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CRIT; i++)
            begin
                bucket_reg[i] <= '0;
            end
        end
        else
        begin
            total_reg <= total_next;
            slice_reg <= slice_next;
            for (int i = 0; i < NUM_CRIT; i++)
            begin
                bucket_reg[i] <= bucket_next[i];
            end
            if (advance)
            begin
                s1_valid_reg  <= q_pop;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_meta_reg <= s1_meta_next;
            if (closing)
            begin
                snap_total_reg <= total_inc;
                for (int i = 0; i < NUM_CRIT; i++)
                begin
                    snap_bucket_reg[i] <= bucket_inc[i];
                end
            end
            s2_meta_reg <= s1_meta_reg;
            for (int i = 0; i < NUM_CRIT; i++)
            begin
                lhs_reg[i] <= PROD_W'(snap_bucket_reg[i]) * PROD_W'(NS_PER_US);
                rhs_reg[i] <= PROD_W'(snap_total_reg) * PROD_W'(cfg.limit[i]);
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_fail_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.criterion_failed |-> out_reg.slice_closed)
        else $error("failure flagged on an open slice");
    a_bucket_needs_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.failed_bucket != '0 |-> out_reg.criterion_failed)
        else $error("failed bucket set without failure");
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        closing |=> total_reg == '0)
        else $error("slice total not cleared on close");
    a_close_advances: assert property (@(posedge clk) disable iff (!rst_n)
        closing |=> slice_reg == $past(slice_reg) + SLICE_W'(1))
        else $error("slice index did not advance on close");
`endif

endmodule

/* sv/latency_slice_pass_checker_core.sv */
// Top level of the latency slice pass checker: configuration registers and
// the front / queue / back chain. Depends on lspc_pkg, lspc_front,
// lspc_queue and lspc_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | in_data  (latency_ns, period_elapsed)
//   out     | out_valid / out_stall| out_data (counted, slice_closed,
//           |                      |           criterion_failed, failed_bucket,
//           |                      |           slice_number)
//   cfg     | cfg_valid / cfg_ready| cfg_index (register), cfg_data (value)
//
// Takes one beat per cycle unless in_stall is high, and returns one result
// beat per input beat; the slice counters and the snapshot update first,
// then a product stage and a compare stage follow.
// Reset clears the counters, the slice index and the pipeline; no clearing
// pass is needed. A four-deep queue parts front and back, so input beats are
// still taken while a result waits on out_stall; in_stall rises when it fills.
// cfg_ready is always high; write only while the block is idle.
module latency_slice_pass_checker_core
    import lspc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lspc_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lspc_out_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lspc_cfg_t cfg_reg;
    lspc_cls_t front_cls;
    lspc_cls_t q_head;
    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_not_empty;

    assign cfg_ready = 1'b1;

    // Configuration registers; thresholds are held already scaled to ns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thr_ns[0]   <= thr_to_ns(USEC_W'(1000));
            cfg_reg.thr_ns[1]   <= thr_to_ns(USEC_W'(8000));
            cfg_reg.thr_ns[2]   <= thr_to_ns(USEC_W'(64000));
            cfg_reg.limit[0]    <= LIMIT_W'(50);
            cfg_reg.limit[1]    <= LIMIT_W'(10);
            cfg_reg.limit[2]    <= LIMIT_W'(1);
            cfg_reg.slice_count <= SLICE_W'(24);
            cfg_reg.disabled    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lspc_reg_t'(cfg_index))
                REG_THR_LOW:     cfg_reg.thr_ns[0]   <= thr_to_ns(cfg_data[USEC_W-1:0]);
                REG_THR_MID:     cfg_reg.thr_ns[1]   <= thr_to_ns(cfg_data[USEC_W-1:0]);
                REG_THR_HIGH:    cfg_reg.thr_ns[2]   <= thr_to_ns(cfg_data[USEC_W-1:0]);
                REG_LIM_LOW:     cfg_reg.limit[0]    <= cfg_data[LIMIT_W-1:0];
                REG_LIM_MID:     cfg_reg.limit[1]    <= cfg_data[LIMIT_W-1:0];
                REG_LIM_HIGH:    cfg_reg.limit[2]    <= cfg_data[LIMIT_W-1:0];
                REG_SLICE_COUNT: cfg_reg.slice_count <= cfg_data[SLICE_W-1:0];
                REG_DISABLE:     cfg_reg.disabled    <= cfg_data[0];
                default:         cfg_reg.disabled    <= cfg_reg.disabled;
            endcase
        end
    end

    // Classify the beat and push it
    lspc_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (front_cls)
    );

    // Hold classified beats until the back end advances
    lspc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cls),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_head)
    );

    // Count, close slices and check the criteria
    lspc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_pop     (q_pop),
        .q_data    (q_head),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for latency_slice_pass_checker_core: predicts every
// result beat in SystemVerilog and checks it field by field.
// Depends on lspc_pkg and the core RTL only.
module tb;
    import lspc_pkg::*;

    localparam int         QUIET_LIMIT = 5000; // cycles with no beat on any channel
    localparam int         HOLD_LEN    = 64;   // long receiver hold-off, in cycles
    localparam logic [63:0] PER_MILLE  = 64'd1000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    lspc_in_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    lspc_out_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the block's registers and slice state
    logic [USEC_W-1:0]     thr_us [NUM_CRIT];
    logic [LIMIT_W-1:0]    lim_pm [NUM_CRIT];
    logic [SLICE_W-1:0]    slice_limit;
    logic                  monitor_off;
    logic [COUNT_BITS-1:0] bucket_tally [NUM_CRIT];
    logic [COUNT_BITS-1:0] slice_total;
    logic [SLICE_W-1:0]    slice_idx;

    // Verdicts predicted at input acceptance, oldest first
    lspc_out_t verdicts_due [$];

    int  mismatches     = 0;
    int  counted_items  = 0;
    int  quiet_cycles   = 0;
    int  send_gap_pct   = 0;
    int  recv_gap_pct   = 0;
    int  elapsed_odds   = 8;
    bit  long_hold      = 1'b0;

    latency_slice_pass_checker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Saturating count: hold at all ones instead of wrapping
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Work out the verdict for one accepted sample and advance the shadow state
    function automatic lspc_out_t judge_sample(input lspc_in_t d);
        lspc_out_t       v;
        logic [NS_W-1:0] usec;
        logic [63:0]     share;
        logic [63:0]     allowed;
        logic            hit;
        int              b;
        v = '0;
        v.slice_number = slice_idx;
        // disabled monitor or a run that is over: drop the sample
        if (monitor_off || slice_idx >= slice_limit)
            return v;
        v.counted = 1'b1;
        usec = d.latency_ns / NS_W'(NS_PER_US);
        slice_total = bump(slice_total);
        // count in the highest bucket whose threshold is strictly exceeded
        hit = 1'b0;
        for (b = NUM_CRIT - 1; b >= 0; b--) begin
            if (!hit && usec > NS_W'(thr_us[b])) begin
                bucket_tally[b] = bump(bucket_tally[b]);
                hit = 1'b1;
            end
        end
        if (!d.period_elapsed)
            return v;
        // close the slice: first bucket with 1000*count >= limit*total fails
        hit = 1'b0;
        for (b = 0; b < NUM_CRIT; b++) begin
            share   = 64'(bucket_tally[b]) * PER_MILLE;
            allowed = 64'(slice_total) * 64'(lim_pm[b]);
            if (!hit && share >= allowed) begin
                hit = 1'b1;
                v.criterion_failed = 1'b1;
                v.failed_bucket = BUCKET_W'(b);
            end
        end
        for (b = 0; b < NUM_CRIT; b++)
            bucket_tally[b] = '0;
        slice_total = '0;
        slice_idx = slice_idx + 1'b1;
        v.slice_closed = 1'b1;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic lspc_in_t sample_of(input logic [NS_W-1:0] ns, input logic done);
        lspc_in_t d;
        d.latency_ns = ns;
        d.period_elapsed = done;
        return d;
    endfunction

    function automatic logic [NS_W-1:0] rand_ns();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Random sample, biased toward the boundaries of the current thresholds
    function automatic lspc_in_t pick_sample();
        logic [NS_W-1:0] brink;
        logic [NS_W-1:0] ns;
        int              k;
        k = $urandom_range(NUM_CRIT - 1);
        // smallest latency that lands above threshold k
        brink = NS_W'(thr_us[k]) * NS_W'(NS_PER_US) + NS_W'(NS_PER_US);
        case ($urandom_range(9))
            0, 1:    ns = rand_ns();
            2, 3, 4: ns = brink + NS_W'($urandom_range(3)) - NS_W'(2);
            5, 6:    ns = rand_ns() % brink;
            default: ns = rand_ns() % (brink + NS_W'(NS_PER_US));
        endcase
        return sample_of(ns, $urandom_range(elapsed_odds - 1) == 0);
    endfunction

    // Offer one beat at the falling edge, with a random gap first; record the
    // verdict at the rising edge that takes it, and return at the next falling edge.
    task automatic send_sample(input lspc_in_t d);
        lspc_out_t v;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        v = judge_sample(d);
        if (v.counted)
            counted_items++;
        verdicts_due.push_back(v);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted verdict has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drive one register write; the caller drops cfg_valid after the last one
    task automatic put_reg(input lspc_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_THR_LOW:     thr_us[0]   = val[USEC_W-1:0];
            REG_THR_MID:     thr_us[1]   = val[USEC_W-1:0];
            REG_THR_HIGH:    thr_us[2]   = val[USEC_W-1:0];
            REG_LIM_LOW:     lim_pm[0]   = val[LIMIT_W-1:0];
            REG_LIM_MID:     lim_pm[1]   = val[LIMIT_W-1:0];
            REG_LIM_HIGH:    lim_pm[2]   = val[LIMIT_W-1:0];
            REG_SLICE_COUNT: slice_limit = val[SLICE_W-1:0];
            REG_DISABLE:     monitor_off = val[0];
            default:         ;
        endcase
        @(negedge clk);
    endtask

    // Rewrite the whole register set. Drain first, then let the pipeline
    // settle so that no beat is in flight during the writes.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] t0, t1, t2,
                                input logic [CFG_DATA_W-1:0] l0, l1, l2,
                                input logic [CFG_DATA_W-1:0] count, off);
        wait_drained();
        repeat (4) @(negedge clk);
        put_reg(REG_THR_LOW, t0);
        put_reg(REG_THR_MID, t1);
        put_reg(REG_THR_HIGH, t2);
        put_reg(REG_LIM_LOW, l0);
        put_reg(REG_LIM_MID, l1);
        put_reg(REG_LIM_HIGH, l2);
        put_reg(REG_SLICE_COUNT, count);
        put_reg(REG_DISABLE, off);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Report a field that differs from its prediction: count it, print a line for the first 40
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (got !== want) begin
            if (mismatches < 40)
                $display("%0t: %s mismatch, got %0h want %0h", $realtime, what, got, want);
            mismatches++;
        end
    endtask

    // Take each result beat at the rising edge and compare with the oldest verdict
    always @(posedge clk) begin
        lspc_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("unexpected result beat", 64'd1, 64'd0);
            end
            else begin
                want = verdicts_due.pop_front();
                report_mismatch("counted", 64'(out_data.counted), 64'(want.counted));
                report_mismatch("slice_closed", 64'(out_data.slice_closed),
                                64'(want.slice_closed));
                report_mismatch("criterion_failed", 64'(out_data.criterion_failed),
                                64'(want.criterion_failed));
                report_mismatch("failed_bucket", 64'(out_data.failed_bucket),
                                64'(want.failed_bucket));
                report_mismatch("slice_number", 64'(out_data.slice_number),
                                64'(want.slice_number));
            end
        end
    end

    // Receiver: stall at random, or hold off for a counted stretch on request
    initial begin
        int held;
        held = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold && held < HOLD_LEN) begin
                out_stall <= 1'b1;
                held++;
            end
            else begin
                if (!long_hold)
                    held = 0;
                out_stall <= ($urandom_range(99) < recv_gap_pct);
            end
        end
    end

    // Watchdog: end the run once no channel has moved a beat for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: every bucket boundary, field extremes, a passing slice
    // and one slice failing on each criterion.
    task automatic test_directed();
        // lone fast sample closes a clean slice
        send_sample(sample_of(48'd0, 1'b1));
        // walk across each threshold: just at it, then just above it
        send_sample(sample_of(48'd1_000_999, 1'b0));
        send_sample(sample_of(48'd1_001_000, 1'b0));
        send_sample(sample_of(48'd8_000_999, 1'b0));
        send_sample(sample_of(48'd8_001_000, 1'b0));
        send_sample(sample_of(48'd64_000_999, 1'b0));
        send_sample(sample_of(48'd64_001_000, 1'b0));
        // largest latency, closing a slice that fails on the low criterion
        send_sample(sample_of('1, 1'b1));
        // slice failing on the middle criterion only
        send_sample(sample_of(48'd8_001_000, 1'b0));
        send_sample(sample_of(48'd0, 1'b1));
        // slice failing on the high criterion only
        send_sample(sample_of(48'd64_001_000, 1'b1));
    endtask

    // Register extremes: zero and full-scale thresholds, zero and over-range
    // limits, data with stray upper bits, a run of zero slices, disabled monitor.
    task automatic test_register_edges();
        // zero thresholds and zero limits: every closed slice fails bucket zero
        program_regs(24'd0, 24'd0, 24'd0, 24'hFFFC00, 24'd0, 24'd0, 24'hFFFF, 24'd0);
        send_sample(sample_of(48'd999, 1'b0));
        send_sample(sample_of(48'd1000, 1'b1));
        // full-scale thresholds, limits at and above 1000
        program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1000, 24'h0003FF,
                     24'hABCFFF, 24'h00FFFF, 24'd0);
        send_sample(sample_of(48'd16_777_215_999, 1'b0));
        send_sample(sample_of(48'd16_777_216_000, 1'b1));
        send_sample(sample_of(48'd16_777_216_000, 1'b1));
        // slice count of zero: every sample runs over
        program_regs(24'd1000, 24'd8000, 24'd64000, 24'd50, 24'd10, 24'd1,
                     24'hFF0000, 24'd0);
        send_sample(sample_of(48'd5_000_000, 1'b0));
        send_sample(sample_of(48'd70_000_000, 1'b1));
        // monitor disabled
        program_regs(24'd1000, 24'd8000, 24'd64000, 24'd50, 24'd10, 24'd1,
                     24'hFFFF, 24'd1);
        send_sample(sample_of(48'd70_000_000, 1'b0));
        send_sample(sample_of(48'd0, 1'b1));
        // stray upper bits on the disable register leave it clear
        program_regs(24'd1000, 24'd8000, 24'd64000, 24'd50, 24'd10, 24'd1,
                     24'hFFFF, 24'hFFFFFE);
        send_sample(sample_of(48'd9_000_000, 1'b0));
        send_sample(sample_of(48'd2_000_000, 1'b1));
    endtask

    // Random settings in segments; keep going until enough samples were counted
    task automatic test_random_traffic(input int quota);
        int                    start;
        int                    burst;
        int                    k;
        logic [USEC_W-1:0]     t [NUM_CRIT];
        logic [LIMIT_W-1:0]    l [NUM_CRIT];
        logic [SLICE_W-1:0]    count;
        logic                  off;
        start = counted_items;
        while (counted_items - start < quota) begin
            case ($urandom_range(3))
                0: begin
                    // ascending and small, so all three buckets see traffic
                    t[0] = USEC_W'($urandom_range(2000));
                    t[1] = t[0] + USEC_W'($urandom_range(10000));
                    t[2] = t[1] + USEC_W'($urandom_range(100000));
                end
                1: begin
                    // descending: the high bucket swallows the others
                    t[2] = USEC_W'($urandom_range(2000));
                    t[1] = t[2] + USEC_W'($urandom_range(10000));
                    t[0] = t[1] + USEC_W'($urandom_range(100000));
                end
                2: begin
                    for (k = 0; k < NUM_CRIT; k++)
                        t[k] = USEC_W'($urandom);
                end
                default: begin
                    for (k = 0; k < NUM_CRIT; k++)
                        t[k] = ($urandom_range(1) == 0) ? '1 : USEC_W'($urandom_range(500));
                end
            endcase
            for (k = 0; k < NUM_CRIT; k++) begin
                case ($urandom_range(4))
                    0:       l[k] = LIMIT_W'($urandom_range(60));
                    1:       l[k] = LIMIT_W'($urandom_range(1023));
                    2:       l[k] = 10'd1000;
                    3:       l[k] = 10'd0;
                    default: l[k] = LIMIT_W'($urandom_range(200));
                endcase
            end
            // now and then end the run a few slices ahead
            count = ($urandom_range(7) == 0) ? slice_idx + SLICE_W'($urandom_range(3)) : '1;
            off   = ($urandom_range(11) == 0);
            elapsed_odds = $urandom_range(2, 12);
            program_regs(t[0], t[1], t[2],
                         {14'($urandom), l[0]}, {14'($urandom), l[1]},
                         {14'($urandom), l[2]},
                         {8'($urandom), count}, {23'($urandom), off});
            burst = off ? 8 : 48;
            repeat (burst)
                send_sample(pick_sample());
        end
    endtask

    // Fill the block behind a long receiver hold-off, then pause the sender
    // mid-slice until every verdict is back.
    task automatic test_backpressure();
        program_regs(24'd1000, 24'd8000, 24'd64000, 24'd50, 24'd10, 24'd1,
                     24'hFFFF, 24'd0);
        elapsed_odds = 6;
        long_hold = 1'b1;
        repeat (30)
            send_sample(pick_sample());
        wait_drained();
        long_hold = 1'b0;
        repeat (3) begin
            repeat (8)
                send_sample(pick_sample());
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int k;
        // drive every input to a known value from time zero
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_THR_LOW;
        cfg_data  = '0;
        // shadow state after reset
        thr_us[0] = 24'd1000;
        thr_us[1] = 24'd8000;
        thr_us[2] = 24'd64000;
        lim_pm[0] = 10'd50;
        lim_pm[1] = 10'd10;
        lim_pm[2] = 10'd1;
        slice_limit = 16'd24;
        monitor_off = 1'b0;
        for (k = 0; k < NUM_CRIT; k++)
            bucket_tally[k] = '0;
        slice_total = '0;
        slice_idx   = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender idles lightly, receiver heavily
        send_gap_pct = 14;
        recv_gap_pct = 52;
        test_directed();
        test_register_edges();
        test_random_traffic(190);

        // swap: sender idles heavily, receiver lightly
        send_gap_pct = 52;
        recv_gap_pct = 14;
        test_random_traffic(190);

        // no idling on either side
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_backpressure();
        test_random_traffic(190);

        // drain, then keep the clock running so that any stray beat shows
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/lspc_pkg.sv
sv/lspc_front.sv
sv/lspc_queue.sv
sv/lspc_back.sv
sv/latency_slice_pass_checker_core.sv
test/tb.sv
